### rtl/cmf_pkg.sv
// Package for the CIE 1931 Gaussian-fit color matching pipeline.
// Holds the lobe coefficients, field widths and the Q30 exponential helper.
`timescale 1ns / 1ps

package cmf_pkg;

   localparam int WL_W    = 14;  // wavelength, Q4
   localparam int X_W     = 18;  // wavelength widened to Q8
   localparam int INV_W   = 13;  // inverse sigma, unsigned Q16
   localparam int ALPHA_W = 16;  // lobe weight, signed Q14
   localparam int T_W     = 31;  // |d| * s, Q24
   localparam int U_W     = 20;  // exponent argument below the cutoff, Q16
   localparam int EXP_W   = 19;  // interpolated exponential, signed Q16
   localparam int LOBE_W  = 35;  // alpha * exp, signed Q30
   localparam int OUT_W   = 17;  // result, signed Q2.14
   localparam int NUM_LOBES = 7;

   // Lobe order: three X lobes, then two Y lobes, then two Z lobes.
   localparam int LOBE_X0 = 0;
   localparam int LOBE_X1 = 1;
   localparam int LOBE_X2 = 2;
   localparam int LOBE_Y0 = 3;
   localparam int LOBE_Y1 = 4;
   localparam int LOBE_Z0 = 5;
   localparam int LOBE_Z1 = 6;

   typedef logic signed [ALPHA_W-1:0] alpha_arr_type [NUM_LOBES];
   typedef logic [X_W-1:0]            mu_arr_type    [NUM_LOBES];
   typedef logic [INV_W-1:0]          inv_arr_type   [NUM_LOBES];

   localparam alpha_arr_type LOBE_ALPHA = '{
      16'sd5931, 16'sd17302, -16'sd1065, 16'sd13451, 16'sd4686, 16'sd19939, 16'sd11158};
   localparam mu_arr_type LOBE_MU = '{
      18'd113152, 18'd153549, 18'd128282, 18'd145613, 18'd135910, 18'd111872, 18'd117504};
   localparam inv_arr_type LOBE_INV_LO = '{
      13'd4089, 13'd1730, 13'd3211, 13'd1396, 13'd4017, 13'd5538, 13'd2523};
   localparam inv_arr_type LOBE_INV_HI = '{
      13'd2451, 13'd2117, 13'd2503, 13'd1619, 13'd2110, 13'd1822, 13'd4751};

   // exp(-x) for x in Q30 within [0, 1], Q30 result, by a 24-term Taylor series.
   // Used only to build constant tables at elaboration.
   function automatic logic [63:0] exp_neg_q30(input logic [63:0] x);
      logic signed [63:0] acc;
      logic [63:0]        term;
      acc  = 64'sd1 <<< 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
         term = ((term * x) >> 30) / 64'(i);
         if (i[0]) begin
            acc = acc - $signed(term);
         end else begin
            acc = acc + $signed(term);
         end
      end
      if (acc < 0) begin
         acc = '0;
      end
      return acc;
   endfunction

endpackage

### rtl/cmf_lobe.sv
// One piecewise Gaussian lobe as a seven-stage pipeline.
// Depends on cmf_pkg for coefficients and widths; builds its exp table locally.
`timescale 1ns / 1ps

module cmf_lobe #(
   parameter int LOBE_IDX        = 0,
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                                clock,
   input  logic                                en,
   input  logic [cmf_pkg::X_W-1:0]             x_q8,
   output logic signed [cmf_pkg::LOBE_W-1:0]   lobe_q30
);

   localparam int IDX_W  = $clog2(EXP_TABLE_DEPTH);
   localparam int IDX1_W = $clog2(EXP_TABLE_DEPTH + 1);
   localparam int PROD_W = cmf_pkg::U_W + IDX1_W;
   localparam int TAB_W  = 17;

   typedef logic [TAB_W-1:0] tab_type [EXP_TABLE_DEPTH + 1];

   // Entry k holds exp(-16k/D) in Q16.
   function automatic tab_type build_table();
      tab_type     tb;
      logic [63:0] e1;
      logic [63:0] e;
      logic [63:0] num;
      logic [63:0] n;
      logic [63:0] r;
      e1 = cmf_pkg::exp_neg_q30(64'd1 << 30);
      for (int k = 0; k <= EXP_TABLE_DEPTH; k++) begin
         num = 64'(16 * k);
         n   = num / EXP_TABLE_DEPTH;
         r   = num % EXP_TABLE_DEPTH;
         e   = cmf_pkg::exp_neg_q30((r << 30) / EXP_TABLE_DEPTH);
         for (int j = 0; j < 16; j++) begin
            if (64'(j) < n) begin
               e = (e * e1 + (64'd1 << 29)) >> 30;
            end
         end
         tb[k] = TAB_W'((e + (64'd1 << 13)) >> 14);
      end
      return tb;
   endfunction

   localparam tab_type EXP_TAB = build_table();

   localparam logic [cmf_pkg::X_W-1:0]   MU     = cmf_pkg::LOBE_MU[LOBE_IDX];
   localparam logic [cmf_pkg::INV_W-1:0] INV_LO = cmf_pkg::LOBE_INV_LO[LOBE_IDX];
   localparam logic [cmf_pkg::INV_W-1:0] INV_HI = cmf_pkg::LOBE_INV_HI[LOBE_IDX];
   localparam logic signed [cmf_pkg::ALPHA_W-1:0] ALPHA = cmf_pkg::LOBE_ALPHA[LOBE_IDX];

   // Stage 1: distance from the center and side selection.
   logic [cmf_pkg::X_W-1:0]   ad_in, ad_ff;
   logic [cmf_pkg::INV_W-1:0] s_in, s_ff;
   // Stage 2: scaled distance.
   logic [cmf_pkg::T_W-1:0]   t_ff;
   // Stage 3: half square, split into cutoff flag and in-range argument.
   logic [2*cmf_pkg::T_W-1:0] sq;
   logic                      cut3_ff;
   logic [cmf_pkg::U_W-1:0]   u_ff;
   // Stage 4: table position.
   logic [PROD_W-1:0]         prod;
   logic                      cut4_ff;
   logic [IDX_W-1:0]          idx_ff;
   logic [15:0]               frac4_ff;
   // Stage 5: table read.
   logic [IDX1_W-1:0]         idx_a, idx_b;
   logic                      cut5_ff;
   logic [15:0]               frac5_ff;
   logic [TAB_W-1:0]          a_ff, b_ff;
   // Stage 6: interpolation.
   logic signed [TAB_W:0]     diff;
   logic signed [TAB_W+17:0]  step;
   logic signed [cmf_pkg::EXP_W-1:0] e_in, e_ff;
   // Stage 7: weighting.
   logic signed [cmf_pkg::LOBE_W-1:0] lobe_ff;

   always_comb begin
      if (x_q8 < MU) begin
         ad_in = MU - x_q8;
         s_in  = INV_LO;
      end else begin
         ad_in = x_q8 - MU;
         s_in  = INV_HI;
      end
   end

   assign sq    = t_ff * t_ff;
   assign prod  = PROD_W'(u_ff) * PROD_W'(EXP_TABLE_DEPTH);
   assign idx_a = IDX1_W'(idx_ff);
   assign idx_b = IDX1_W'(idx_ff) + IDX1_W'(1);

   always_comb begin
      diff = $signed({1'b0, a_ff}) - $signed({1'b0, b_ff});
      step = diff * $signed({1'b0, frac5_ff});
      e_in = cmf_pkg::EXP_W'($signed({1'b0, a_ff})) - cmf_pkg::EXP_W'(step >>> 16);
      if (cut5_ff) begin
         e_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ad_ff    <= ad_in;
         s_ff     <= s_in;
         t_ff     <= cmf_pkg::T_W'(ad_ff) * cmf_pkg::T_W'(s_ff);
         cut3_ff  <= |sq[2*cmf_pkg::T_W-1 : 33 + cmf_pkg::U_W];
         u_ff     <= sq[33 +: cmf_pkg::U_W];
         cut4_ff  <= cut3_ff;
         idx_ff   <= prod[cmf_pkg::U_W +: IDX_W];
         frac4_ff <= prod[19:4];
         cut5_ff  <= cut4_ff;
         frac5_ff <= frac4_ff;
         a_ff     <= EXP_TAB[idx_a];
         b_ff     <= EXP_TAB[idx_b];
         e_ff     <= e_in;
         lobe_ff  <= cmf_pkg::LOBE_W'(ALPHA) * cmf_pkg::LOBE_W'(e_ff);
      end
   end

   assign lobe_q30 = lobe_ff;

endmodule

### rtl/cmf_sum.sv
// Sums up to three Q30 lobes, rounds half up to Q14 and saturates to Q2.14.
// Depends on cmf_pkg for widths.
`timescale 1ns / 1ps

module cmf_sum (
   input  logic signed [cmf_pkg::LOBE_W-1:0] lobe_a,
   input  logic signed [cmf_pkg::LOBE_W-1:0] lobe_b,
   input  logic signed [cmf_pkg::LOBE_W-1:0] lobe_c,
   output logic signed [cmf_pkg::OUT_W-1:0]  cmf_q14
);

   localparam int SUM_W = cmf_pkg::LOBE_W + 2;
   localparam int RND_W = SUM_W - 16;

   logic signed [SUM_W-1:0] sum;
   logic signed [RND_W-1:0] rnd;

   always_comb begin
      sum = SUM_W'(lobe_a) + SUM_W'(lobe_b) + SUM_W'(lobe_c) + SUM_W'(1 << 15);
      rnd = RND_W'(sum >>> 16);
      if (rnd > RND_W'(65535)) begin
         cmf_q14 = cmf_pkg::OUT_W'(65535);
      end else if (rnd < -RND_W'(65536)) begin
         cmf_q14 = -cmf_pkg::OUT_W'(65536);
      end else begin
         cmf_q14 = cmf_pkg::OUT_W'(rnd);
      end
   end

endmodule

### rtl/cie_cmf_gaussian_fit.sv
// Top level of the CIE 1931 color matching pipeline (multi-lobe Gaussian fit).
// Depends on cmf_pkg, cmf_lobe and cmf_sum.
`timescale 1ns / 1ps
//
// Usage:
//   The request channel takes one word per accepted handshake: a wavelength in
//   nanometers with four fraction bits. The response channel returns one word
//   per request, carrying the X, Y and Z matching values in signed Q2.14.
//   A word moves at a rising edge where valid is high and stall is low.
// Stages and throughput:
//   A word passes eight register stages: seven inside each lobe unit (distance,
//   scaling, squaring, table position, table read, interpolation, weighting)
//   and one for the sum, rounding and saturation. The response word is held in
//   the output register and is taken at a rising edge where rsp_stall is low.
//   The pipeline takes one word every cycle while the output is not stalled.
// Stalls:
//   When the output register holds a word and the receiver stalls, the whole
//   pipeline freezes and req_stall rises in the same cycle; nothing is lost
//   or repeated, and bubbles are carried as cleared valid bits.
// Reset:
//   Synchronous reset clears the valid bits only; the data path needs none.
//   The exponential table is a constant built at elaboration, so no warm-up.

module cie_cmf_gaussian_fit #(
   parameter int EXP_TABLE_DEPTH = 256
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic [cmf_pkg::WL_W-1:0]           req_wavelength_q4,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [cmf_pkg::OUT_W-1:0]   rsp_cmf_x,
   output logic signed [cmf_pkg::OUT_W-1:0]   rsp_cmf_y,
   output logic signed [cmf_pkg::OUT_W-1:0]   rsp_cmf_z
);

   localparam int DEPTH = 8;

   logic                               en;
   logic [DEPTH-1:0]                   vld_in, vld_ff;
   logic [cmf_pkg::X_W-1:0]            x_q8;
   logic signed [cmf_pkg::LOBE_W-1:0]  lobe [cmf_pkg::NUM_LOBES];
   logic signed [cmf_pkg::OUT_W-1:0]   x_in, y_in, z_in;
   logic signed [cmf_pkg::OUT_W-1:0]   x_ff, y_ff, z_ff;

   // The pipeline advances unless a finished word is held by the receiver.
   assign en        = !(vld_ff[DEPTH-1] && rsp_stall);
   assign req_stall = !en;
   assign x_q8      = {req_wavelength_q4, 4'b0000};
   assign vld_in    = {vld_ff[DEPTH-2:0], req_valid};

   for (genvar g = 0; g < cmf_pkg::NUM_LOBES; g++) begin : g_lobe
      cmf_lobe #(
         .LOBE_IDX        (g),
         .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
      ) u_lobe (
         .clock    (clock),
         .en       (en),
         .x_q8     (x_q8),
         .lobe_q30 (lobe[g])
      );
   end

   cmf_sum u_sum_x (
      .lobe_a  (lobe[cmf_pkg::LOBE_X0]),
      .lobe_b  (lobe[cmf_pkg::LOBE_X1]),
      .lobe_c  (lobe[cmf_pkg::LOBE_X2]),
      .cmf_q14 (x_in)
   );

   cmf_sum u_sum_y (
      .lobe_a  (lobe[cmf_pkg::LOBE_Y0]),
      .lobe_b  (lobe[cmf_pkg::LOBE_Y1]),
      .lobe_c  ('0),
      .cmf_q14 (y_in)
   );

   cmf_sum u_sum_z (
      .lobe_a  (lobe[cmf_pkg::LOBE_Z0]),
      .lobe_b  (lobe[cmf_pkg::LOBE_Z1]),
      .lobe_c  ('0),
      .cmf_q14 (z_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff <= x_in;
         y_ff <= y_in;
         z_ff <= z_in;
      end
   end

   assign rsp_valid = vld_ff[DEPTH-1];
   assign rsp_cmf_x = x_ff;
   assign rsp_cmf_y = y_ff;
   assign rsp_cmf_z = z_ff;

   // An accepted request enters the first stage.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // A frozen pipeline keeps every valid bit.
   a_freeze: assert property (@(posedge clock) disable iff (reset)
      !en |=> (vld_ff == $past(vld_ff)))
      else $error("valid bits moved while the pipeline was frozen");

   // Back pressure only comes from a held output word.
   a_stall_src: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled without a held response");

endmodule

### test/tb_cie_cmf_gaussian_fit.sv
// Testbench for cie_cmf_gaussian_fit: streams wavelengths, predicts X, Y and Z.
// Depends on cmf_pkg (widths and lobe constants) and the RTL of the block.
`timescale 1ns / 1ps

module tb_cie_cmf_gaussian_fit;

   localparam int TABLE_DEPTH = 256;
   localparam int CYCLE_LIMIT = 400000;

   // A predicted color matching triple.
   typedef struct {
      logic signed [cmf_pkg::OUT_W-1:0] x;
      logic signed [cmf_pkg::OUT_W-1:0] y;
      logic signed [cmf_pkg::OUT_W-1:0] z;
   } cmf_triple_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [cmf_pkg::WL_W-1:0] req_wavelength_q4 = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic signed [cmf_pkg::OUT_W-1:0] rsp_cmf_x, rsp_cmf_y, rsp_cmf_z;

   cie_cmf_gaussian_fit #(.EXP_TABLE_DEPTH(TABLE_DEPTH)) i_dut (.*);

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // Exponential samples exp(-16k/D) in Q16, built with integer arithmetic only.
   longint unsigned exp_points [TABLE_DEPTH+1];

   // Series expansion of exp(-arg) with the argument and result in Q30.
   function automatic longint unsigned taylor_exp_q30(input longint unsigned arg);
      longint signed acc;
      longint unsigned term;
      acc = 64'sd1 << 30;
      term = 64'd1 << 30;
      for (int i = 1; i <= 24; i++) begin
         term = ((term * arg) >> 30) / i;
         if (i % 2 == 1) begin
            acc = acc - longint'(term);
         end else begin
            acc = acc + longint'(term);
         end
      end
      if (acc < 0) begin
         acc = 0;
      end
      return longint'(acc);
   endfunction

   task automatic build_exp_points();
      longint unsigned e_one, e, whole, rem;
      e_one = taylor_exp_q30(64'd1 << 30);
      for (int k = 0; k <= TABLE_DEPTH; k++) begin
         whole = (16 * k) / TABLE_DEPTH;
         rem = (16 * k) % TABLE_DEPTH;
         e = taylor_exp_q30((rem << 30) / TABLE_DEPTH);
         for (int j = 0; j < whole; j++) begin
            e = (e * e_one + (64'd1 << 29)) >> 30;
         end
         exp_points[k] = (e + (64'd1 << 13)) >> 14;
      end
   endtask

   // One lobe, alpha * exp(-u), in Q30. The upper sigma applies at the center.
   function automatic longint signed lobe_weight_q30(input int n, input longint signed xq8);
      longint signed delta;
      longint unsigned mag, sig, t, u, pos, idx, frac, a, b, ev;
      delta = xq8 - longint'(cmf_pkg::LOBE_MU[n]);
      mag = (delta < 0) ? -delta : delta;
      sig = (delta < 0) ? cmf_pkg::LOBE_INV_LO[n] : cmf_pkg::LOBE_INV_HI[n];
      t = mag * sig;
      u = (t * t) >> 33;
      if (u >= (64'd16 << 16)) begin
         return 0;
      end
      pos = (u * TABLE_DEPTH) >> 4;
      idx = pos >> 16;
      frac = pos & 64'hFFFF;
      if (idx >= TABLE_DEPTH) begin
         ev = exp_points[TABLE_DEPTH];
      end else begin
         a = exp_points[idx];
         b = exp_points[idx+1];
         ev = a - (((a - b) * frac) >> 16);
      end
      return longint'(cmf_pkg::LOBE_ALPHA[n]) * longint'(ev);
   endfunction

   // Rounds a Q30 sum half up to Q14 and clips it to the output range.
   function automatic logic signed [cmf_pkg::OUT_W-1:0] round_saturate(input longint signed s);
      longint signed v;
      v = (s + (64'sd1 << 15)) >>> 16;
      if (v > 65535) begin
         v = 65535;
      end
      if (v < -65536) begin
         v = -65536;
      end
      return v[cmf_pkg::OUT_W-1:0];
   endfunction

   function automatic cmf_triple_type predict_cmf(input logic [cmf_pkg::WL_W-1:0] wl);
      cmf_triple_type r;
      longint signed xq8;
      xq8 = longint'(wl) << 4;
      r.x = round_saturate(lobe_weight_q30(cmf_pkg::LOBE_X0, xq8)
                           + lobe_weight_q30(cmf_pkg::LOBE_X1, xq8)
                           + lobe_weight_q30(cmf_pkg::LOBE_X2, xq8));
      r.y = round_saturate(lobe_weight_q30(cmf_pkg::LOBE_Y0, xq8)
                           + lobe_weight_q30(cmf_pkg::LOBE_Y1, xq8));
      r.z = round_saturate(lobe_weight_q30(cmf_pkg::LOBE_Z0, xq8)
                           + lobe_weight_q30(cmf_pkg::LOBE_Z1, xq8));
      return r;
   endfunction

   logic [cmf_pkg::WL_W-1:0] pending_wavelengths [$];
   cmf_triple_type expected_cmf [$];
   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int hold_off_cycles = 0;
   int cycle_count = 0;
   int error_count = 0;
   bit stimulus_done = 1'b0;

   // The stall as seen at the last rising edge decides whether the word left.
   logic req_stall_seen = 1'b0;
   always @(posedge clock) begin
      req_stall_seen <= req_stall;
   end

   // Driver: offers the next wavelength from the queue at the falling edge.
   // A word stays on the port until it is taken; the prediction is made then.
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall_seen) begin
            expected_cmf.push_back(predict_cmf(req_wavelength_q4));
            void'(pending_wavelengths.pop_front());
         end
         if (pending_wavelengths.size() > 0
             && ((req_valid && req_stall_seen) || $urandom_range(99) >= send_idle_pct)) begin
            req_valid <= 1'b1;
            req_wavelength_q4 <= pending_wavelengths[0];
         end else begin
            req_valid <= 1'b0;
            req_wavelength_q4 <= cmf_pkg::WL_W'($urandom);
         end
      end
   end

   // Receiver stall: a long hold-off when asked, random idling otherwise.
   always @(negedge clock) begin
      if (hold_off_cycles > 0) begin
         hold_off_cycles <= hold_off_cycles - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Monitor: each response word is checked against the oldest prediction.
   always @(posedge clock) begin
      cmf_triple_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_cmf.size() == 0) begin
            $display("%t: response word with no request pending: x=%0d y=%0d z=%0d",
                     $realtime, rsp_cmf_x, rsp_cmf_y, rsp_cmf_z);
            error_count++;
         end else begin
            want = expected_cmf.pop_front();
            if (rsp_cmf_x !== want.x) begin
               $display("%t: cmf_x expected %0d actual %0d", $realtime, want.x, rsp_cmf_x);
               error_count++;
            end
            if (rsp_cmf_y !== want.y) begin
               $display("%t: cmf_y expected %0d actual %0d", $realtime, want.y, rsp_cmf_y);
               error_count++;
            end
            if (rsp_cmf_z !== want.z) begin
               $display("%t: cmf_z expected %0d actual %0d", $realtime, want.z, rsp_cmf_z);
               error_count++;
            end
         end
      end
   end

   // Watchdog on the total run length.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Queues random wavelengths: mostly across the visible band where the lobes
   // live, some anywhere in the field range.
   task automatic queue_random(input int count);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(3) != 0) begin
            pending_wavelengths.push_back(
               cmf_pkg::WL_W'($urandom_range(380 * 16, 830 * 16)));
         end else begin
            pending_wavelengths.push_back(cmf_pkg::WL_W'($urandom));
         end
      end
   endtask

   task automatic wait_drained();
      while (pending_wavelengths.size() > 0 || expected_cmf.size() > 0) begin
         @(posedge clock);
      end
   endtask

   initial begin
      int mu_q4;
      build_exp_points();
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed words: field extremes, two alternating bit patterns, every lobe
      // center (the side switch) and its neighbors, and far tails past the cutoff.
      pending_wavelengths.push_back('0);
      pending_wavelengths.push_back({cmf_pkg::WL_W{1'b1}});
      pending_wavelengths.push_back(cmf_pkg::WL_W'(14'h2AAA));
      pending_wavelengths.push_back(cmf_pkg::WL_W'(14'h1555));
      for (int n = 0; n < cmf_pkg::NUM_LOBES; n++) begin
         mu_q4 = cmf_pkg::LOBE_MU[n] >> 4;
         pending_wavelengths.push_back(cmf_pkg::WL_W'(mu_q4));
         pending_wavelengths.push_back(cmf_pkg::WL_W'(mu_q4 - 1));
         pending_wavelengths.push_back(cmf_pkg::WL_W'(mu_q4 + 1));
      end
      pending_wavelengths.push_back(cmf_pkg::WL_W'(360 * 16));
      pending_wavelengths.push_back(cmf_pkg::WL_W'(900 * 16));

      // Long receiver hold-off while the sender keeps offering words.
      send_idle_pct = 0;
      hold_off_cycles = 60;
      queue_random(40);
      wait_drained();

      send_idle_pct = 17;
      recv_idle_pct = 65;
      queue_random(560);
      wait_drained();
      send_idle_pct = 65;
      recv_idle_pct = 17;
      queue_random(560);
      wait_drained();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      queue_random(560);
      wait_drained();

      repeat (20) @(posedge clock);
      if (error_count == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
